// ===== rtl/core/ptp_pkg.sv =====
// package for the palette text parser
// types, codes and byte tables shared by front, queue and back
package ptp_pkg;

    localparam int NAME_COUNT_MAX = 255;
    localparam int COL_W = 32;
    localparam logic [COL_W-1:0] COL_CAP = 32'h8000_0000;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] KIND_ENTRY = 3'd0;
    localparam logic [2:0] KIND_NAME = 3'd1;
    localparam logic [2:0] KIND_COLUMNS = 3'd2;
    localparam logic [2:0] KIND_OK = 3'd3;
    localparam logic [2:0] KIND_FAIL = 3'd4;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_MAGIC = 2'd2;
    localparam logic [1:0] ERR_ENTRY = 2'd3;

    localparam logic [2:0] PH_MAGIC = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_BODY = 3'd2;
    localparam logic [2:0] PH_BADMAGIC = 3'd3;
    localparam logic [2:0] PH_BADENTRY = 3'd4;

    localparam logic [2:0] CL_BLANK = 3'd0;
    localparam logic [2:0] CL_COMMENT = 3'd1;
    localparam logic [2:0] CL_PREFIX = 3'd2;
    localparam logic [2:0] CL_NAME = 3'd3;
    localparam logic [2:0] CL_COLUMNS = 3'd4;
    localparam logic [2:0] CL_CHANNELS = 3'd5;
    localparam logic [2:0] CL_ENTRY = 3'd6;
    localparam logic [2:0] CL_BAD = 3'd7;

    // classified byte handed from front to back
    typedef struct packed {
        logic       is_end;
        logic       is_lf;
        logic       is_ws;
        logic       is_dig;
        logic [3:0] digit;
        logic [7:0] data;
    } tok_t;

    function automatic logic [7:0] magic_byte(input logic [3:0] p);
        logic [7:0] b;
        begin
            case (p)
                4'd0: b = 8'h47;
                4'd1: b = 8'h49;
                4'd2: b = 8'h4D;
                4'd3: b = 8'h50;
                4'd4: b = 8'h20;
                4'd5: b = 8'h50;
                4'd6: b = 8'h61;
                4'd7: b = 8'h6C;
                4'd8: b = 8'h65;
                4'd9: b = 8'h74;
                4'd10: b = 8'h74;
                4'd11: b = 8'h65;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    // prefix text: Name, Columns, Channels
    function automatic logic [7:0] prefix_byte(input logic [1:0] k, input logic [3:0] p);
        logic [7:0] b;
        begin
            b = 8'h00;
            case (k)
                2'd0:
                begin
                    case (p)
                        4'd0: b = "N";
                        4'd1: b = "a";
                        4'd2: b = "m";
                        4'd3: b = "e";
                        default: b = 8'h00;
                    endcase
                end
                2'd1:
                begin
                    case (p)
                        4'd0: b = "C";
                        4'd1: b = "o";
                        4'd2: b = "l";
                        4'd3: b = "u";
                        4'd4: b = "m";
                        4'd5: b = "n";
                        4'd6: b = "s";
                        default: b = 8'h00;
                    endcase
                end
                2'd2:
                begin
                    case (p)
                        4'd0: b = "C";
                        4'd1: b = "h";
                        4'd2: b = "a";
                        4'd3: b = "n";
                        4'd4: b = "n";
                        4'd5: b = "e";
                        4'd6: b = "l";
                        4'd7: b = "s";
                        default: b = 8'h00;
                    endcase
                end
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    function automatic logic [3:0] prefix_len(input logic [1:0] k);
        logic [3:0] n;
        begin
            case (k)
                2'd0: n = 4'd4;
                2'd1: n = 4'd7;
                2'd2: n = 4'd8;
                default: n = 4'd0;
            endcase
            return n;
        end
    endfunction

endpackage

// ===== rtl/core/ptp_front.sv =====
// front end: takes bytes and commands, classifies each into a token
// uses ptp_pkg
module ptp_front (
    input  logic          valid,
    output logic          stall,
    input  logic          command,
    input  logic [7:0]    data_byte,
    output logic          tok_valid,
    output ptp_pkg::tok_t tok,
    input  logic          tok_stall
);
    ptp_pkg::tok_t tok_next;

    // a held token only blocks while the queue refuses it
    assign stall = tok_stall;
    assign tok_valid = valid;

    always_comb
    begin
        tok_next.is_end = command;
        tok_next.is_lf = !command && (data_byte == 8'd10);
        tok_next.is_ws = (data_byte == 8'd32) || (data_byte inside {[8'd9:8'd13]});
        tok_next.is_dig = data_byte inside {[8'd48:8'd57]};
        tok_next.digit = 4'(data_byte - 8'd48);
        tok_next.data = data_byte;
    end

    assign tok = tok_next;
endmodule

// ===== rtl/core/ptp_queue.sv =====
// short token queue between front and back
// uses ptp_pkg
module ptp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ptp_pkg::tok_t in_tok,
    output logic          out_valid,
    input  logic          out_stall,
    output ptp_pkg::tok_t out_tok
);
    ptp_pkg::tok_t slot_reg [ptp_pkg::QUEUE_DEPTH];
    logic [ptp_pkg::QUEUE_AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [ptp_pkg::QUEUE_AW:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_stall = (cnt_reg == (ptp_pkg::QUEUE_AW+1)'(ptp_pkg::QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_tok = slot_reg[rd_reg];
    assign push = in_valid && !in_stall;
    assign pop = out_valid && !out_stall;

    always_comb
    begin
        wr_next = push ? wr_reg + 1'b1 : wr_reg;
        rd_next = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + {{ptp_pkg::QUEUE_AW{1'b0}}, push}
                   - {{ptp_pkg::QUEUE_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_tok;
        end
    end
endmodule

// ===== rtl/core/ptp_back.sv =====
// back end: line state machine, number accumulation and result registers
// uses ptp_pkg; a two-row output buffer lets an end token emit two results
module ptp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tok_valid,
    output logic          tok_stall,
    input  ptp_pkg::tok_t tok,
    output logic          valid,
    input  logic          stall,
    output logic [2:0]    kind,
    output logic [7:0]    red,
    output logic [7:0]    green,
    output logic [7:0]    blue,
    output logic [7:0]    name_length,
    output logic [30:0]   columns,
    output logic [1:0]    error_code,
    output logic          last
);
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  name_length;
        logic [30:0] columns;
        logic [1:0]  error_code;
        logic        last;
    } row_t;

    logic [2:0] phase_reg, phase_next;
    logic [3:0] pos_reg, pos_next;
    logic       mism_reg, mism_next;
    logic [2:0] cls_reg, cls_next;
    logic [2:0] cand_reg, cand_next;
    logic [1:0] nidx_reg, nidx_next;
    logic       dseen_reg, dseen_next;
    logic [8:0] acc_reg [3];
    logic [8:0] acc_next [3];
    logic [7:0] ntot_reg, ntot_next, ntrim_reg, ntrim_next;
    logic [31:0] col_reg, col_next;
    logic [3:0] cf_reg, cf_next;
    logic       any_reg, any_next;

    // output buffer: up to two rows
    row_t buf_reg [2];
    row_t buf_next [2];
    logic [1:0] bcnt_reg, bcnt_next;

    row_t r0, r1;
    logic [1:0] nrows;
    logic take, pop;
    logic [7:0] c;

    assign pop = (bcnt_reg != 2'd0) && !stall;
    // take a token only when the buffer can hold two rows after this cycle's pop
    assign tok_stall = (bcnt_reg == 2'd2) || (bcnt_reg == 2'd1 && stall);
    assign take = tok_valid && !tok_stall;
    assign c = tok.data;

    assign valid = (bcnt_reg != 2'd0);
    assign kind = buf_reg[0].kind;
    assign red = buf_reg[0].red;
    assign green = buf_reg[0].green;
    assign blue = buf_reg[0].blue;
    assign name_length = buf_reg[0].name_length;
    assign columns = buf_reg[0].columns;
    assign error_code = buf_reg[0].error_code;
    assign last = buf_reg[0].last;

    function automatic logic [8:0] acc_step(input logic [8:0] a, input logic [3:0] d);
        logic [12:0] v;
        begin
            v = {a, 3'b0} + {3'b0, a, 1'b0} + {9'b0, d};
            return (v > 13'd256) ? 9'd256 : v[8:0];
        end
    endfunction

    function automatic logic [7:0] clamp8(input logic [8:0] a);
        return a[8] ? 8'd255 : a[7:0];
    endfunction

    always_comb
    begin
        logic [2:0] row_cls;
        logic [2:0] row_ph;
        logic       emit_line;
        logic       do_line;
        logic [1:0] err;
        logic [35:0] cv;
        logic       name_mode;
        logic       blank_ws;
        logic       col_ok;

        phase_next = phase_reg;
        pos_next = pos_reg;
        mism_next = mism_reg;
        cls_next = cls_reg;
        cand_next = cand_reg;
        nidx_next = nidx_reg;
        dseen_next = dseen_reg;
        acc_next = acc_reg;
        ntot_next = ntot_reg;
        ntrim_next = ntrim_reg;
        col_next = col_reg;
        cf_next = cf_reg;
        any_next = any_reg;
        r0 = '0;
        r1 = '0;
        nrows = 2'd0;
        emit_line = 1'b0;
        do_line = 1'b0;
        err = ptp_pkg::ERR_NONE;
        cv = '0;
        name_mode = 1'b0;
        blank_ws = 1'b0;
        col_ok = 1'b0;
        row_cls = cls_reg;
        row_ph = phase_reg;

        if (take)
        begin
            if (!tok.is_end && !tok.is_lf)
            begin
                any_next = 1'b1;
                if (phase_reg == ptp_pkg::PH_MAGIC)
                begin
                    if (pos_reg < 4'd12)
                    begin
                        if (c != ptp_pkg::magic_byte(pos_reg)) mism_next = 1'b1;
                    end
                    else if (!(pos_reg == 4'd12 && c == 8'd13))
                    begin
                        mism_next = 1'b1;
                    end
                end
                else if (phase_reg == ptp_pkg::PH_HEADER || phase_reg == ptp_pkg::PH_BODY)
                begin
                    // resolve the class for this byte
                    if (cls_reg == ptp_pkg::CL_BLANK)
                    begin
                        if (tok.is_ws) blank_ws = 1'b1;
                        else if (c == "#") cls_next = ptp_pkg::CL_COMMENT;
                        else if (phase_reg == ptp_pkg::PH_HEADER && pos_reg == 4'd0
                                 && (c == "N" || c == "C"))
                            cls_next = ptp_pkg::CL_PREFIX;
                        else if (tok.is_dig) cls_next = ptp_pkg::CL_ENTRY;
                        else cls_next = ptp_pkg::CL_BAD;
                    end
                    if (!blank_ws)
                    begin
                        case (cls_next)
                            ptp_pkg::CL_PREFIX:
                            begin
                                for (int k = 0; k < 3; k++)
                                begin
                                    if (cls_next == ptp_pkg::CL_PREFIX && cand_next[k])
                                    begin
                                        if (pos_reg < ptp_pkg::prefix_len(2'(k)))
                                        begin
                                            if (c != ptp_pkg::prefix_byte(2'(k), pos_reg))
                                                cand_next[k] = 1'b0;
                                        end
                                        else if (pos_reg == ptp_pkg::prefix_len(2'(k))
                                                 && c == ":")
                                        begin
                                            cls_next = ptp_pkg::CL_NAME + 3'(k);
                                        end
                                        else
                                        begin
                                            cand_next[k] = 1'b0;
                                        end
                                    end
                                end
                                if (cls_next == ptp_pkg::CL_PREFIX && cand_next == 3'b0)
                                    cls_next = ptp_pkg::CL_BAD;
                            end
                            ptp_pkg::CL_NAME:
                            begin
                                if (cls_reg == ptp_pkg::CL_NAME) name_mode = 1'b1;
                            end
                            ptp_pkg::CL_COLUMNS:
                            begin
                                if (cls_reg == ptp_pkg::CL_COLUMNS && !cf_reg[3])
                                begin
                                    if (!cf_reg[0] && tok.is_ws)
                                    begin
                                        cf_next = cf_reg;
                                    end
                                    else if (!cf_reg[0] && c == "+")
                                    begin
                                        cf_next[0] = 1'b1;
                                    end
                                    else if (!cf_reg[0] && c == "-")
                                    begin
                                        cf_next[0] = 1'b1;
                                        cf_next[1] = 1'b1;
                                    end
                                    else
                                    begin
                                        cf_next[0] = 1'b1;
                                        if (tok.is_dig)
                                        begin
                                            cv = {col_reg, 3'b0} + {3'b0, col_reg, 1'b0}
                                                 + {32'b0, tok.digit};
                                            col_next = (cv > {4'b0, ptp_pkg::COL_CAP})
                                                       ? ptp_pkg::COL_CAP : cv[31:0];
                                            cf_next[2] = 1'b1;
                                        end
                                        else
                                        begin
                                            cf_next[3] = 1'b1;
                                        end
                                    end
                                end
                            end
                            ptp_pkg::CL_ENTRY:
                            begin
                                if (nidx_reg == 2'd3)
                                begin
                                    name_mode = 1'b1;
                                end
                                else if (tok.is_dig)
                                begin
                                    acc_next[nidx_reg] = acc_step(acc_reg[nidx_reg], tok.digit);
                                    dseen_next = 1'b1;
                                end
                                else if (dseen_reg && nidx_reg == 2'd2)
                                begin
                                    dseen_next = 1'b0;
                                    nidx_next = 2'd3;
                                    name_mode = 1'b1;
                                end
                                else
                                begin
                                    if (dseen_reg)
                                    begin
                                        dseen_next = 1'b0;
                                        nidx_next = nidx_reg + 2'd1;
                                    end
                                    if (!tok.is_ws) cls_next = ptp_pkg::CL_BAD;
                                end
                            end
                            default:
                            begin
                                cls_next = cls_next;
                            end
                        endcase
                        if (name_mode && !(ntot_reg == 8'd0 && tok.is_ws))
                        begin
                            ntot_next = (ntot_reg < 8'(ptp_pkg::NAME_COUNT_MAX))
                                        ? ntot_reg + 8'd1 : ntot_reg;
                            if (!tok.is_ws) ntrim_next = ntot_next;
                        end
                    end
                end
                if (pos_reg < 4'd15) pos_next = pos_reg + 4'd1;
            end
            else
            begin
                if (tok.is_lf)
                begin
                    any_next = 1'b1;
                    do_line = 1'b1;
                end
                else
                begin
                    do_line = (pos_reg != 4'd0) && (phase_reg <= ptp_pkg::PH_BODY);
                end
                if (do_line)
                begin
                    if (phase_reg == ptp_pkg::PH_MAGIC)
                    begin
                        row_ph = (!mism_reg && pos_reg >= 4'd12)
                                 ? ptp_pkg::PH_HEADER : ptp_pkg::PH_BADMAGIC;
                    end
                    else if (phase_reg == ptp_pkg::PH_HEADER
                             || phase_reg == ptp_pkg::PH_BODY)
                    begin
                        case (row_cls)
                            ptp_pkg::CL_NAME:
                            begin
                                emit_line = 1'b1;
                                r0.kind = ptp_pkg::KIND_NAME;
                                r0.name_length = ntrim_reg;
                            end
                            ptp_pkg::CL_COLUMNS:
                            begin
                                emit_line = 1'b1;
                                col_ok = cf_reg[2] && !cf_reg[1]
                                         && (col_reg < ptp_pkg::COL_CAP);
                                r0.kind = ptp_pkg::KIND_COLUMNS;
                                r0.columns = col_ok ? col_reg[30:0] : 31'd0;
                            end
                            ptp_pkg::CL_ENTRY:
                            begin
                                if (nidx_reg == 2'd3 || (nidx_reg == 2'd2 && dseen_reg))
                                begin
                                    emit_line = 1'b1;
                                    r0.kind = ptp_pkg::KIND_ENTRY;
                                    r0.red = clamp8(acc_reg[0]);
                                    r0.green = clamp8(acc_reg[1]);
                                    r0.blue = clamp8(acc_reg[2]);
                                    r0.name_length = ntrim_reg;
                                    row_ph = ptp_pkg::PH_BODY;
                                end
                                else
                                begin
                                    row_ph = ptp_pkg::PH_BADENTRY;
                                end
                            end
                            ptp_pkg::CL_PREFIX, ptp_pkg::CL_BAD:
                            begin
                                row_ph = ptp_pkg::PH_BADENTRY;
                            end
                            default:
                            begin
                                row_ph = phase_reg;
                            end
                        endcase
                    end
                end
                // clear the line
                pos_next = '0;
                mism_next = 1'b0;
                cls_next = ptp_pkg::CL_BLANK;
                cand_next = 3'b111;
                nidx_next = '0;
                dseen_next = 1'b0;
                acc_next[0] = '0;
                acc_next[1] = '0;
                acc_next[2] = '0;
                ntot_next = '0;
                ntrim_next = '0;
                col_next = '0;
                cf_next = '0;
                phase_next = row_ph;
                if (tok.is_lf)
                begin
                    if (emit_line)
                    begin
                        r0.last = 1'b1;
                        nrows = 2'd1;
                    end
                end
                else
                begin
                    if (!any_reg) err = ptp_pkg::ERR_EMPTY;
                    else if (row_ph == ptp_pkg::PH_BADMAGIC) err = ptp_pkg::ERR_MAGIC;
                    else if (row_ph == ptp_pkg::PH_BADENTRY) err = ptp_pkg::ERR_ENTRY;
                    r1.kind = (err != ptp_pkg::ERR_NONE) ? ptp_pkg::KIND_FAIL
                                                         : ptp_pkg::KIND_OK;
                    r1.error_code = err;
                    r1.last = 1'b1;
                    if (emit_line)
                    begin
                        nrows = 2'd2;
                    end
                    else
                    begin
                        r0 = r1;
                        nrows = 2'd1;
                    end
                    phase_next = ptp_pkg::PH_MAGIC;
                    any_next = 1'b0;
                end
            end
        end
    end

    // output buffer update
    always_comb
    begin
        logic [1:0] keep;
        buf_next = buf_reg;
        keep = bcnt_reg;
        if (pop)
        begin
            buf_next[0] = buf_reg[1];
            keep = bcnt_reg - 2'd1;
        end
        if (nrows != 2'd0)
        begin
            if (keep == 2'd0)
            begin
                buf_next[0] = r0;
                buf_next[1] = r1;
            end
            else
            begin
                buf_next[1] = r0;
            end
        end
        bcnt_next = keep + nrows;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ptp_pkg::PH_MAGIC;
            pos_reg <= '0;
            mism_reg <= 1'b0;
            cls_reg <= ptp_pkg::CL_BLANK;
            cand_reg <= 3'b111;
            nidx_reg <= '0;
            dseen_reg <= 1'b0;
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
            ntot_reg <= '0;
            ntrim_reg <= '0;
            col_reg <= '0;
            cf_reg <= '0;
            any_reg <= 1'b0;
            bcnt_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            mism_reg <= mism_next;
            cls_reg <= cls_next;
            cand_reg <= cand_next;
            nidx_reg <= nidx_next;
            dseen_reg <= dseen_next;
            acc_reg <= acc_next;
            ntot_reg <= ntot_next;
            ntrim_reg <= ntrim_next;
            col_reg <= col_next;
            cf_reg <= cf_next;
            any_reg <= any_next;
            bcnt_reg <= bcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end
endmodule

// ===== rtl/core/palette_text_parser.sv =====
// top level of the palette text parser
// uses ptp_pkg, ptp_front, ptp_queue and ptp_back
//
// input channel: valid/stall with command (0 byte, 1 end of input) and
// data_byte. one item is taken per cycle while stall is low.
// output channel: valid/stall with kind, red, green, blue, name_length,
// columns, error_code and last. a name, columns or complete entry line emits
// its row when its LF arrives, end of input emits the ok/failed row, preceded
// by the row of an unterminated last line, so one item gives at most two rows.
// a byte reaches the back end through a four-entry token queue; its token is
// registered in the queue and its row in the back end's output buffer.
// throughput: one item per cycle while no stall holds the flow, set by the line
// update in the back end; an end item with two rows stalls the back end until
// its first row has left the output.
// a receiver stall holds the back end once a row waits in its output
// buffer, the queue then fills and raises stall on the input; nothing is lost.
// reset clears the parser to the magic line state and empties the queue
// and output buffer. after end of input the parser is ready for a new file.
module palette_text_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  name_length,
    output logic [30:0] columns,
    output logic [1:0]  error_code,
    output logic        last
);
    logic          f_valid, f_stall, q_valid, q_stall;
    ptp_pkg::tok_t f_tok, q_tok;

    ptp_front u_front (
        .valid     (in_valid),
        .stall     (in_stall),
        .command   (command),
        .data_byte (data_byte),
        .tok_valid (f_valid),
        .tok       (f_tok),
        .tok_stall (f_stall)
    );

    ptp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_stall  (f_stall),
        .in_tok    (f_tok),
        .out_valid (q_valid),
        .out_stall (q_stall),
        .out_tok   (q_tok)
    );

    ptp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (q_valid),
        .tok_stall   (q_stall),
        .tok         (q_tok),
        .valid       (out_valid),
        .stall       (out_stall),
        .kind        (kind),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .name_length (name_length),
        .columns     (columns),
        .error_code  (error_code),
        .last        (last)
    );
endmodule

// ===== rtl/core/ptp_checker.sv =====
// port-level checks for the palette text parser
// bound to palette_text_parser
module ptp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [1:0]  error_code,
    input logic [30:0] columns,
    input logic [7:0]  red,
    input logic        last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind))
        else $error("output item changed while stalled");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != ptp_pkg::KIND_FAIL |-> error_code == ptp_pkg::ERR_NONE)
        else $error("error code on non-failure item");

    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == ptp_pkg::KIND_FAIL |-> error_code != ptp_pkg::ERR_NONE && last)
        else $error("bad failure item");

    a_cols: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != ptp_pkg::KIND_COLUMNS |-> columns == 31'd0)
        else $error("columns on wrong kind");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == ptp_pkg::KIND_OK |-> last && red == 8'd0)
        else $error("bad ok item");
endmodule

bind palette_text_parser ptp_checker u_ptp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .error_code (error_code),
    .columns    (columns),
    .red        (red),
    .last       (last)
);

// ===== dv/tb.sv =====
// testbench for palette_text_parser: byte streams of palette files, checked row by row
// depends on ptp_pkg and palette_text_parser; self-contained predictor inside
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  name_length;
        logic [30:0] columns;
        logic [1:0]  error_code;
        logic        last;
    } row_t;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END = 1'b1;
    localparam logic [3:0] CF_START = 4'd1;
    localparam logic [3:0] CF_NEG = 4'd2;
    localparam logic [3:0] CF_DIG = 4'd4;
    localparam logic [3:0] CF_STOP = 4'd8;
    localparam int LIMIT_CYCLES = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = 1'b0;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  red, green, blue, name_length;
    logic [30:0] columns;
    logic [1:0]  error_code;
    logic        last;

    palette_text_parser uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .data_byte(data_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .red(red), .green(green), .blue(blue),
        .name_length(name_length), .columns(columns),
        .error_code(error_code), .last(last)
    );

    always #4 clk = ~clk;

    row_t expected_rows[$];
    int   error_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_cycles = 0;
    int   cycle_count = 0;
    int   sent_count = 0;

    // predictor state
    logic [2:0]  p_phase;
    logic [3:0]  p_pos;
    logic        p_mismatch, p_cr;
    logic [2:0]  p_class;
    logic [2:0]  p_cand;
    logic [1:0]  p_num;
    logic        p_dseen;
    logic [8:0]  p_acc[3];
    logic [7:0]  p_ntot, p_ntrim;
    logic [63:0] p_cols;
    logic [3:0]  p_cflags;
    logic        p_any;

    function automatic bit is_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // magic first line, built from the package table
    function automatic string magic_line();
        string s;
        s = "";
        for (int i = 0; i < 12; i++)
            s = {s, string'(ptp_pkg::magic_byte(4'(i)))};
        return s;
    endfunction

    task automatic clear_line_state();
        p_pos = 0; p_mismatch = 0; p_cr = 0; p_class = ptp_pkg::CL_BLANK; p_cand = 3'b111;
        p_num = 0; p_dseen = 0; p_acc[0] = 0; p_acc[1] = 0; p_acc[2] = 0;
        p_ntot = 0; p_ntrim = 0; p_cols = 0; p_cflags = 0;
    endtask

    task automatic reset_parser_state();
        clear_line_state();
        p_phase = ptp_pkg::PH_MAGIC;
        p_any = 0;
    endtask

    task automatic count_name_char(logic [7:0] c);
        if (p_ntot == 0 && is_space(c))
            return;
        if (p_ntot < ptp_pkg::NAME_COUNT_MAX)
            p_ntot++;
        if (!is_space(c))
            p_ntrim = p_ntot;
    endtask

    task automatic entry_byte(logic [7:0] c);
        logic [12:0] v;
        if (p_num >= 3)
        begin
            count_name_char(c);
            return;
        end
        if (is_digit(c))
        begin
            v = 13'(p_acc[p_num] * 10 + (c - "0"));
            p_acc[p_num] = v > 256 ? 9'd256 : v[8:0];
            p_dseen = 1;
            return;
        end
        if (p_dseen)
        begin
            p_dseen = 0;
            p_num++;
            if (p_num == 3)
            begin
                count_name_char(c);
                return;
            end
        end
        if (!is_space(c))
            p_class = ptp_pkg::CL_BAD;
    endtask

    task automatic columns_byte(logic [7:0] c);
        logic [63:0] v;
        if (p_cflags & CF_STOP)
            return;
        if (!(p_cflags & CF_START))
        begin
            if (is_space(c))
                return;
            p_cflags |= CF_START;
            if (c == "+")
                return;
            if (c == "-")
            begin
                p_cflags |= CF_NEG;
                return;
            end
        end
        if (is_digit(c))
        begin
            v = p_cols * 10 + (c - "0");
            p_cols = v > 64'h8000_0000 ? 64'h8000_0000 : v;
            p_cflags |= CF_DIG;
        end
        else
            p_cflags |= CF_STOP;
    endtask

    task automatic prefix_byte_step(logic [7:0] c);
        string words[3] = '{"Name", "Columns", "Channels"};
        for (int k = 0; k < 3; k++)
        begin
            if (!p_cand[k])
                continue;
            if (p_pos < words[k].len())
            begin
                if (c != words[k][p_pos])
                    p_cand[k] = 0;
            end
            else if (p_pos == words[k].len() && c == ":")
            begin
                p_class = ptp_pkg::CL_NAME + 3'(k);
                return;
            end
            else
                p_cand[k] = 0;
        end
        if (p_cand == 0)
            p_class = ptp_pkg::CL_BAD;
    endtask

    task automatic text_byte(logic [7:0] c);
        if (p_phase == ptp_pkg::PH_MAGIC)
        begin
            if (p_pos < 12)
            begin
                if (c != ptp_pkg::magic_byte(p_pos))
                    p_mismatch = 1;
            end
            else if (p_pos == 12 && c == 8'd13)
                p_cr = 1;
            else
                p_mismatch = 1;
        end
        else if (p_phase == ptp_pkg::PH_HEADER || p_phase == ptp_pkg::PH_BODY)
        begin
            case (p_class)
                ptp_pkg::CL_BLANK:
                begin
                    if (!is_space(c))
                    begin
                        if (c == "#")
                            p_class = ptp_pkg::CL_COMMENT;
                        else if (p_phase == ptp_pkg::PH_HEADER && p_pos == 0
                                 && (c == "N" || c == "C"))
                        begin
                            p_class = ptp_pkg::CL_PREFIX;
                            prefix_byte_step(c);
                        end
                        else if (is_digit(c))
                        begin
                            p_class = ptp_pkg::CL_ENTRY;
                            entry_byte(c);
                        end
                        else
                            p_class = ptp_pkg::CL_BAD;
                    end
                end
                ptp_pkg::CL_PREFIX: prefix_byte_step(c);
                ptp_pkg::CL_NAME: count_name_char(c);
                ptp_pkg::CL_COLUMNS: columns_byte(c);
                ptp_pkg::CL_ENTRY: entry_byte(c);
                default: ;
            endcase
        end
        if (p_pos < 15)
            p_pos++;
    endtask

    function automatic logic [7:0] clamp255(logic [8:0] v);
        return v > 255 ? 8'd255 : v[7:0];
    endfunction

    task automatic finish_line(inout row_t rows[$]);
        row_t r;
        r = '0;
        if (p_phase == ptp_pkg::PH_MAGIC)
            p_phase = (!p_mismatch && p_pos >= 12) ? ptp_pkg::PH_HEADER : ptp_pkg::PH_BADMAGIC;
        else if (p_phase == ptp_pkg::PH_HEADER || p_phase == ptp_pkg::PH_BODY)
        begin
            case (p_class)
                ptp_pkg::CL_NAME:
                begin
                    r.kind = ptp_pkg::KIND_NAME;
                    r.name_length = p_ntrim;
                    rows = {rows, r};
                end
                ptp_pkg::CL_COLUMNS:
                begin
                    r.kind = ptp_pkg::KIND_COLUMNS;
                    if ((p_cflags & CF_DIG) && !(p_cflags & CF_NEG) && p_cols < 64'h8000_0000)
                        r.columns = p_cols[30:0];
                    rows = {rows, r};
                end
                ptp_pkg::CL_ENTRY:
                begin
                    if (p_num == 3 || (p_num == 2 && p_dseen))
                    begin
                        r.kind = ptp_pkg::KIND_ENTRY;
                        r.red = clamp255(p_acc[0]);
                        r.green = clamp255(p_acc[1]);
                        r.blue = clamp255(p_acc[2]);
                        r.name_length = p_ntrim;
                        rows = {rows, r};
                        p_phase = ptp_pkg::PH_BODY;
                    end
                    else
                        p_phase = ptp_pkg::PH_BADENTRY;
                end
                ptp_pkg::CL_PREFIX, ptp_pkg::CL_BAD: p_phase = ptp_pkg::PH_BADENTRY;
                default: ;
            endcase
        end
        clear_line_state();
    endtask

    task automatic predict_rows(logic cmd, logic [7:0] c);
        row_t rows[$];
        row_t r;
        if (cmd == CMD_BYTE)
        begin
            p_any = 1;
            if (c == 8'd10)
                finish_line(rows);
            else
                text_byte(c);
        end
        else
        begin
            r = '0;
            if (p_pos > 0 && p_phase <= ptp_pkg::PH_BODY)
                finish_line(rows);
            if (!p_any)
                r.error_code = ptp_pkg::ERR_EMPTY;
            else if (p_phase == ptp_pkg::PH_BADMAGIC)
                r.error_code = ptp_pkg::ERR_MAGIC;
            else if (p_phase == ptp_pkg::PH_BADENTRY)
                r.error_code = ptp_pkg::ERR_ENTRY;
            r.kind = r.error_code != ptp_pkg::ERR_NONE ? ptp_pkg::KIND_FAIL
                                                       : ptp_pkg::KIND_OK;
            rows = {rows, r};
            reset_parser_state();
        end
        if (rows.size() > 0)
            rows[rows.size()-1].last = 1;
        foreach (rows[i])
            expected_rows = {expected_rows, rows[i]};
    endtask

    // sends one item; valid stays high across back-to-back items
    task automatic send_item(logic cmd, logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        predict_rows(cmd, c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(CMD_BYTE, s[i]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_rows.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= $urandom_range(99) < recv_idle_pct;
    end

    // result checker
    always @(posedge clk)
    begin
        row_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind, red, green, blue, name_length, columns, error_code, last};
            if (expected_rows.size() == 0)
            begin
                $display("%0t unexpected row %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (got.kind != want.kind || got.red != want.red || got.green != want.green
                    || got.blue != want.blue || got.name_length != want.name_length
                    || got.columns != want.columns || got.error_code != want.error_code
                    || got.last != want.last)
                begin
                    $display("%0t mismatch: expected k%0d rgb %0d %0d %0d len %0d col %0d e%0d l%0d",
                             $time, want.kind, want.red, want.green, want.blue,
                             want.name_length, want.columns, want.error_code, want.last);
                    $display("%0t            actual k%0d rgb %0d %0d %0d len %0d col %0d e%0d l%0d",
                             $time, got.kind, got.red, got.green, got.blue,
                             got.name_length, got.columns, got.error_code, got.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(CMD_END, 8'd0);
        send_text({magic_line(), "\n"});
        send_item(CMD_END, 8'd0);
        send_text({magic_line(), "\r\nName: My Pal  \r\nColumns: 16\nChannels: RGBA\n"});
        send_text("Columns: -3\nColumns:+99999999999\n# c\n \n");
        send_text("0 0 0\n999 256 255 hi there  \n  1\t2 3name\n");
        send_item(CMD_BYTE, 8'd255);
        send_item(CMD_BYTE, 8'd128);
        send_text("\n4 5 6");
        send_item(CMD_END, 8'd0);
        send_text({magic_line().substr(0, 10), "x\n1 2 3\n"});
        send_item(CMD_END, 8'd0);
        send_text({magic_line(), "\nNam: x\n"});
        send_item(CMD_END, 8'd0);
        send_text({magic_line(), "\n1 2\n"});
        send_item(CMD_END, 8'd0);
        send_text({magic_line(), "\n1 2 3\nName: late\n"});
        send_item(CMD_END, 8'd0);
    endtask

    function automatic string rand_number(int maxlen);
        string s = "";
        int n = $urandom_range(maxlen, 1);
        for (int i = 0; i < n; i++)
            s = {s, string'(8'("0" + $urandom_range(9)))};
        return s;
    endfunction

    function automatic string rand_ws();
        byte w[6] = '{8'd32, 8'd9, 8'd11, 8'd12, 8'd13, 8'd32};
        return string'(w[$urandom_range(5)]);
    endfunction

    task automatic send_random_file();
        string line;
        string magic;
        int nlines = $urandom_range(8, 1);
        int mode = $urandom_range(9);
        magic = magic_line();
        if (mode == 0)
            for (int i = 0; i < 20; i++)
                send_item(CMD_BYTE, 8'($urandom_range(255)));
        else if ($urandom_range(9) == 0)
            send_text({magic.substr(0, 3), " ", magic.substr(4, 11), "\n"});
        else
            send_text({magic, "\n"});
        for (int i = 0; i < nlines; i++)
        begin
            case ($urandom_range(9))
                0: line = {"Name:", rand_ws(), rand_number(3), " x", rand_ws()};
                1: line = {"Columns:", $urandom_range(1) ? "-" : "+", rand_number(12)};
                2: line = {"Channels: RGB"};
                3: line = {"# ", rand_number(3)};
                4: line = {rand_ws(), "Cx:"};
                default:
                    line = {rand_ws(), rand_number(4), rand_ws(), rand_number(3),
                            rand_ws(), rand_number(3), $urandom_range(1) ? rand_ws() : "",
                            $urandom_range(1) ? {"n", rand_number(2), rand_ws()} : ""};
            endcase
            send_text(line);
            if ($urandom_range(15) == 0)
                send_item(CMD_BYTE, 8'($urandom_range(255)));
            if (i < nlines - 1 || $urandom_range(1))
                send_item(CMD_BYTE, 8'd10);
        end
        send_item(CMD_END, 8'($urandom_range(255)));
    endtask

    task automatic test_random(int items);
        int start_count = sent_count;
        while (sent_count - start_count < items)
            send_random_file();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        send_text({magic_line(), "\n"});
        for (int i = 0; i < 12; i++)
            send_text("1 2 3\n");
        send_item(CMD_END, 8'd0);
    endtask

    task automatic test_long_name();
        send_text({magic_line(), "\nName:"});
        for (int i = 0; i < 300; i++)
            send_item(CMD_BYTE, "a");
        send_text("\n1 2 3 ");
        for (int i = 0; i < 300; i++)
            send_item(CMD_BYTE, "b");
        send_item(CMD_END, 8'd0);
    endtask

    initial
    begin
        reset_parser_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 17;
        recv_idle_pct = 56;
        test_directed();
        test_random(220);
        send_idle_pct = 56;
        recv_idle_pct = 17;
        test_long_name();
        test_random(220);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(220);
        drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/ptp_pkg.sv
rtl/core/ptp_front.sv
rtl/core/ptp_queue.sv
rtl/core/ptp_back.sv
rtl/core/palette_text_parser.sv
rtl/core/ptp_checker.sv
dv/tb.sv
